[sv/cpsa_pkg.sv]
// ----------------------------------------------------------------------------
// cpsa_pkg
// Shared types, constants and helper functions of the colored page slot
// allocator.
// ----------------------------------------------------------------------------
package cpsa_pkg;

	localparam int MAX_ALIGNS = 256;
	localparam int MAX_SETS   = 4;
	localparam int PAGE_SHIFT = 12;

	localparam int ALIGN_W    = $clog2(MAX_ALIGNS);
	localparam int SET_W      = $clog2(MAX_SETS);
	localparam int ADDR_W     = 32;
	localparam int AV_W       = ADDR_W - PAGE_SHIFT;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 88;
	localparam int M_TDATA_W  = 16;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_NO_SLOT  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_OUTSIDE  = 3'd3,
		ST_UNUSED   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VAC_MODE     = 4'd0,
		REG_COLORING_EN  = 4'd1,
		REG_ALIGN_COUNT  = 4'd2,
		REG_SET_COUNT    = 4'd3,
		REG_COLOR_MASK   = 4'd4,
		REG_SET_SHIFT    = 4'd5,
		REG_WINDOW_START = 4'd6,
		REG_WINDOW_END   = 4'd7
	} reg_idx_t;

	// Configuration as seen by the controller, counts already turned into masks.
	typedef struct packed {
		logic              vac_mode;
		logic              coloring_enable;
		logic [ALIGN_W-1:0] align_mask;
		logic [SET_W-1:0]   set_mask;
		logic [ADDR_W-1:0]  color_mask;
		logic [4:0]         set_shift;
		logic [ADDR_W-1:0]  window_start;
		logic [ADDR_W-1:0]  window_end;
	} cfg_t;

	// One request to the slot table: a row read and a row write.
	typedef struct packed {
		logic               rd_en;
		logic [ALIGN_W-1:0] rd_addr;
		logic               wr_en;
		logic [ALIGN_W-1:0] wr_addr;
		logic [MAX_SETS-1:0] wr_row;
	} ram_req_t;

	// Clamp to 1..MAX_ALIGNS, round down to a power of two, return count - 1.
	function automatic logic [ALIGN_W-1:0] align_mask_of(input logic [ALIGN_W:0] v);
		logic [ALIGN_W-1:0] m;
		m = '0;
		for (int i = 0; i < ALIGN_W; i++) begin
			if (v[i]) begin
				m = ALIGN_W'((1 << i) - 1);
			end
		end
		if (v >= (ALIGN_W+1)'(MAX_ALIGNS)) begin
			m = '1;
		end
		return m;
	endfunction

	// Same for the set count.
	function automatic logic [SET_W-1:0] set_mask_of(input logic [SET_W:0] v);
		logic [SET_W-1:0] m;
		m = '0;
		for (int i = 0; i < SET_W; i++) begin
			if (v[i]) begin
				m = SET_W'((1 << i) - 1);
			end
		end
		if (v >= (SET_W+1)'(MAX_SETS)) begin
			m = '1;
		end
		return m;
	endfunction

endpackage

[sv/cpsa_cfg.sv]
// ----------------------------------------------------------------------------
// cpsa_cfg
// Configuration registers with their reset values and the derived masks.
// ----------------------------------------------------------------------------
module cpsa_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpsa_pkg::CFG_DATA_W-1:0] cfg_data,
	output cpsa_pkg::cfg_t                  cfg
);

	logic                            vac_mode_q;
	logic                            coloring_enable_q;
	logic [cpsa_pkg::ALIGN_W:0]      align_count_q;
	logic [cpsa_pkg::SET_W:0]        set_count_q;
	logic [cpsa_pkg::ADDR_W-1:0]     color_mask_q;
	logic [4:0]                      set_shift_q;
	logic [cpsa_pkg::ADDR_W-1:0]     window_start_q;
	logic [cpsa_pkg::ADDR_W-1:0]     window_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vac_mode_q        <= 1'b0;
			coloring_enable_q <= 1'b0;
			align_count_q     <= (cpsa_pkg::ALIGN_W+1)'(64);
			set_count_q       <= (cpsa_pkg::SET_W+1)'(2);
			color_mask_q      <= 32'h0003_FFFF;
			set_shift_q       <= 5'd18;
			window_start_q    <= '0;
			window_end_q      <= 32'h0007_FFFF;
		end else if (cfg_we) begin
			unique case (cpsa_pkg::reg_idx_t'(cfg_index))
				cpsa_pkg::REG_VAC_MODE:     vac_mode_q        <= cfg_data[0];
				cpsa_pkg::REG_COLORING_EN:  coloring_enable_q <= cfg_data[0];
				cpsa_pkg::REG_ALIGN_COUNT:  align_count_q     <= cfg_data[cpsa_pkg::ALIGN_W:0];
				cpsa_pkg::REG_SET_COUNT:    set_count_q       <= cfg_data[cpsa_pkg::SET_W:0];
				cpsa_pkg::REG_COLOR_MASK:   color_mask_q      <= cfg_data;
				cpsa_pkg::REG_SET_SHIFT:    set_shift_q       <= cfg_data[4:0];
				cpsa_pkg::REG_WINDOW_START: window_start_q    <= cfg_data;
				cpsa_pkg::REG_WINDOW_END:   window_end_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.vac_mode        = vac_mode_q;
		cfg.coloring_enable = coloring_enable_q;
		cfg.align_mask      = cpsa_pkg::align_mask_of(align_count_q);
		cfg.set_mask        = cpsa_pkg::set_mask_of(set_count_q);
		cfg.color_mask      = color_mask_q;
		cfg.set_shift       = set_shift_q;
		cfg.window_start    = window_start_q;
		cfg.window_end      = window_end_q;
	end

endmodule

[sv/cpsa_slot_ram.sv]
// ----------------------------------------------------------------------------
// cpsa_slot_ram
// Slot table: one row per alignment, one in-use bit per set. Registered read.
// ----------------------------------------------------------------------------
module cpsa_slot_ram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cpsa_pkg::ram_req_t               req,
	output logic [cpsa_pkg::MAX_SETS-1:0]    rd_row
);

	logic [cpsa_pkg::MAX_SETS-1:0]   mem [cpsa_pkg::MAX_ALIGNS];
	logic [cpsa_pkg::MAX_ALIGNS-1:0] valid_q;
	logic [cpsa_pkg::MAX_SETS-1:0]   data_s1;
	logic                            vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_row;
		end
		if (req.rd_en) begin
			data_s1 <= mem[req.rd_addr];
		end
	end

	// A row never written since reset reads as all sets free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_row = vld_s1 ? data_s1 : '0;

endmodule

[sv/cpsa_ctrl.sv]
// ----------------------------------------------------------------------------
// cpsa_ctrl
// Request sequencer: start alignment selection, row-per-cycle search,
// release read-modify-write and the result register.
// ----------------------------------------------------------------------------
module cpsa_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpsa_pkg::cfg_t                      cfg,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                kind,
	input  logic signed [cpsa_pkg::ALIGN_W:0]   existing_align,
	input  logic [7:0]                          page_color,
	input  logic [cpsa_pkg::ADDR_W-1:0]         avoid_addr,
	input  logic [cpsa_pkg::ADDR_W-1:0]         release_addr,
	output cpsa_pkg::ram_req_t                  ram_req,
	input  logic [cpsa_pkg::MAX_SETS-1:0]       rd_row,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output cpsa_pkg::status_t                   status,
	output logic [cpsa_pkg::ALIGN_W-1:0]        slot_align,
	output logic [cpsa_pkg::SET_W-1:0]          slot_set
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SEARCH,
		S_RELEASE,
		S_DONE
	} state_t;

	localparam int AW = cpsa_pkg::ALIGN_W;
	localparam int SW = cpsa_pkg::SET_W;

	state_t                      state_q;
	logic [AW-1:0]               next_align_q;

	// Captured item
	logic                        kind_q;
	logic [AW:0]                 ex_q;
	logic [7:0]                  color_q;
	logic [cpsa_pkg::ADDR_W-1:0] avoid_q;
	logic [cpsa_pkg::ADDR_W-1:0] raddr_q;

	// Working registers
	logic [AW-1:0]               align_q;
	logic [AW-1:0]               last_q;
	logic                        direct_q;
	logic                        first_q;
	logic [SW-1:0]               rset_q;
	cpsa_pkg::status_t           res_status_q;
	logic [AW-1:0]               res_align_q;
	logic [SW-1:0]               res_set_q;

	// Start selection
	logic [AW-1:0]               last0;
	logic [AW-1:0]               last_rr;
	logic [AW-1:0]               pick;
	logic [AW-1:0]               pick_adj;
	logic [cpsa_pkg::ADDR_W-1:0] av_full;
	logic [cpsa_pkg::AV_W-1:0]   av;
	logic [AW-1:0]               start;
	logic [AW-1:0]               last_new;
	logic                        direct_new;

	// Release decode
	logic                        in_win;
	logic [AW-1:0]               rel_align;
	logic [cpsa_pkg::ADDR_W-1:0] rel_shifted;
	logic [SW-1:0]               rel_set;

	// Row search
	logic [cpsa_pkg::MAX_SETS-1:0] set_en;
	logic [cpsa_pkg::MAX_SETS-1:0] free;
	logic                          found;
	logic [SW-1:0]                 fset;
	logic [AW-1:0]                 nxt;
	logic                          rel_used;

	always_comb begin
		last0    = next_align_q & cfg.align_mask;
		last_rr  = (last0 + AW'(1)) & cfg.align_mask;
		pick     = cfg.coloring_enable ? (color_q[AW-1:0] & cfg.align_mask) : last0;
		av_full  = avoid_q & cfg.color_mask;
		av       = av_full[cpsa_pkg::ADDR_W-1:cpsa_pkg::PAGE_SHIFT];
		pick_adj = (av == cpsa_pkg::AV_W'(pick)) ? ((pick + AW'(1)) & cfg.align_mask) : pick;

		if (!cfg.vac_mode) begin
			start      = last0;
			last_new   = last0;
			direct_new = 1'b0;
		end else if (!ex_q[AW]) begin
			start      = ex_q[AW-1:0] & cfg.align_mask;
			last_new   = last0;
			direct_new = 1'b1;
		end else begin
			start      = pick_adj;
			last_new   = cfg.coloring_enable ? last0 : last_rr;
			direct_new = 1'b0;
		end

		in_win      = !((raddr_q < cfg.window_start) || (raddr_q > cfg.window_end));
		rel_align   = raddr_q[cpsa_pkg::PAGE_SHIFT +: AW] & cfg.align_mask;
		rel_shifted = raddr_q >> cfg.set_shift;
		rel_set     = rel_shifted[SW-1:0] & cfg.set_mask;

		for (int i = 0; i < cpsa_pkg::MAX_SETS; i++) begin
			set_en[i] = (SW'(i) & ~cfg.set_mask) == '0;
		end
		free  = ~rd_row & set_en;
		found = |free;
		fset  = '0;
		for (int i = cpsa_pkg::MAX_SETS - 1; i >= 0; i--) begin
			if (free[i]) begin
				fset = SW'(i);
			end
		end
		nxt      = (align_q + AW'(1)) & cfg.align_mask;
		rel_used = rd_row[rset_q];
	end

	// Slot table requests
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_START: begin
				ram_req.rd_en   = !kind_q || in_win;
				ram_req.rd_addr = kind_q ? rel_align : start;
			end
			S_SEARCH: begin
				if (found) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = align_q;
					ram_req.wr_row  = rd_row | (cpsa_pkg::MAX_SETS'(1) << fset);
				end else if (nxt != last_q) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = nxt;
				end
			end
			S_RELEASE: begin
				ram_req.wr_en   = rel_used;
				ram_req.wr_addr = align_q;
				ram_req.wr_row  = rd_row & ~(cpsa_pkg::MAX_SETS'(1) << rset_q);
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	// Item capture and working registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q  <= kind;
			ex_q    <= existing_align;
			color_q <= page_color;
			avoid_q <= avoid_addr;
			raddr_q <= release_addr;
		end
		case (state_q)
			S_START: begin
				first_q  <= 1'b1;
				direct_q <= direct_new;
				last_q   <= last_new;
				if (kind_q) begin
					align_q      <= rel_align;
					rset_q       <= rel_set;
					res_status_q <= cpsa_pkg::ST_OUTSIDE;
					res_align_q  <= '0;
					res_set_q    <= '0;
				end else begin
					align_q <= start;
				end
			end
			S_SEARCH: begin
				first_q <= 1'b0;
				if (found) begin
					res_status_q <= cpsa_pkg::ST_GRANTED;
					res_align_q  <= align_q;
					res_set_q    <= fset;
				end else begin
					align_q      <= nxt;
					res_status_q <= cpsa_pkg::ST_NO_SLOT;
					res_align_q  <= '0;
					res_set_q    <= '0;
				end
			end
			S_RELEASE: begin
				res_status_q <= rel_used ? cpsa_pkg::ST_RELEASED : cpsa_pkg::ST_UNUSED;
				res_align_q  <= align_q;
				res_set_q    <= rset_q;
			end
			default: ;
		endcase
	end

	// State, round-robin pointer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_align_q <= '0;
			m_tvalid     <= 1'b0;
			status       <= cpsa_pkg::ST_GRANTED;
			slot_align   <= '0;
			slot_set     <= '0;
		end else begin
			// The output register empties on a handshake, unless the done
			// state loads the next result in the same cycle.
			if (m_tvalid && m_tready && (state_q != S_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (!kind_q) begin
						state_q <= S_SEARCH;
					end else if (in_win) begin
						state_q <= S_RELEASE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SEARCH: begin
					if (found) begin
						if (!(direct_q && first_q)) begin
							next_align_q <= align_q;
						end
						state_q <= S_DONE;
					end else if (nxt == last_q) begin
						next_align_q <= nxt;
						state_q      <= S_DONE;
					end
				end
				S_RELEASE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid   <= 1'b1;
						status     <= res_status_q;
						slot_align <= res_align_q;
						slot_set   <= res_set_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/colored_page_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// colored_page_slot_allocator_top
// Hands out cache-color-consistent mapping slots from an alignment by set
// table and frees them again.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake           Contents
//   cfg       in    cfg_we              cfg_index selects register, cfg_data value
//   s_*       in    s_tvalid/s_tready   map request or release item
//   m_*       out   m_tvalid/m_tready   status, slot alignment, slot set
//
// One item is in work at a time. The search of a map request reads from one
// up to the alignment count of alignment rows; the slot table delivers one
// row per cycle through its single read port. A release reads its row and
// writes it back with the set cleared if that set was in use; an address
// outside the window does not touch the slot table.
// The slot table needs no clearing pass: a valid bit per row, cleared by
// reset, makes unwritten rows read as free, so items are taken right after
// reset. A stalled result stays in the output register while the next item
// is accepted; that item waits for the register to empty before its own
// result is loaded.
//
module colored_page_slot_allocator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cpsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpsa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// existing_align[8:0], page_color[16:9], avoid_addr[48:17],
	// release_addr[80:49], zero fill [87:81]
	input  logic [cpsa_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind: 0 map request, 1 release
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], slot_align[10:3], slot_set[12:11], zero fill [15:13]
	output logic [cpsa_pkg::M_TDATA_W-1:0]   m_tdata
);

	cpsa_pkg::cfg_t                     cfg;
	cpsa_pkg::ram_req_t                 ram_req;
	logic [cpsa_pkg::MAX_SETS-1:0]      rd_row;
	cpsa_pkg::status_t                  status;
	logic [cpsa_pkg::ALIGN_W-1:0]       slot_align;
	logic [cpsa_pkg::SET_W-1:0]         slot_set;

	// Configuration registers; the counts arrive as masks.
	cpsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The slot table itself.
	cpsa_slot_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rd_row (rd_row)
	);

	// Sequencer: picks the start alignment, walks the rows, grants or frees
	// a slot and holds the result until the sink takes it.
	cpsa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.kind           (s_tuser),
		.existing_align (s_tdata[8:0]),
		.page_color     (s_tdata[16:9]),
		.avoid_addr     (s_tdata[48:17]),
		.release_addr   (s_tdata[80:49]),
		.ram_req        (ram_req),
		.rd_row         (rd_row),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.status         (status),
		.slot_align     (slot_align),
		.slot_set       (slot_set)
	);

	assign m_tdata = {3'b000, slot_set, slot_align, status};

endmodule

[sv/cpsa_checker.sv]
// ----------------------------------------------------------------------------
// cpsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cpsa_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [cpsa_pkg::M_TDATA_W-1:0]   m_tdata
);

	// A clock edge under reset leaves the output register empty.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result shown during reset");

	// Only defined status codes leave the block, with zero fill above.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= cpsa_pkg::ST_UNUSED) && (m_tdata[15:13] == 3'b000))
		else $error("undefined status or nonzero fill");

	// No slot and outside window name no slot.
	a_no_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[2:0] == cpsa_pkg::ST_NO_SLOT) ||
		             (m_tdata[2:0] == cpsa_pkg::ST_OUTSIDE))
		|-> (m_tdata[12:3] == '0))
		else $error("slot fields set on a refusal");

	// One item at a time: an accepted item blocks the input for the next cycle.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accept");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind colored_page_slot_allocator_top cpsa_checker u_cpsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
